FILE: hw/rtl/pscc_pkg.sv
// Shared types, opcodes, status codes and operand tables of the packed stack core.
// No dependencies; used by the core, its divider, its port checker and the testbench.
package pscc_pkg;

  localparam int CELL_BITS = 32;
  localparam int MAX_DEV   = 16;

  typedef logic [CELL_BITS-1:0] cell_t;
  typedef logic [7:0]           opcode_t;
  typedef logic [3:0]           status_t;
  typedef logic [1:0]           mode_t;
  typedef logic [1:0]           rdir_t;

  localparam mode_t MODE_LOAD  = 2'd0;
  localparam mode_t MODE_START = 2'd1;
  localparam mode_t MODE_EXEC  = 2'd2;
  localparam mode_t MODE_ARM   = 2'd3;

  localparam status_t ST_OK       = 4'd0;
  localparam status_t ST_FINISHED = 4'd1;
  localparam status_t ST_HALTED   = 4'd2;
  localparam status_t ST_BAD_OP   = 4'd3;
  localparam status_t ST_D_UNDER  = 4'd4;
  localparam status_t ST_D_OVER   = 4'd5;
  localparam status_t ST_R_UNDER  = 4'd6;
  localparam status_t ST_R_OVER   = 4'd7;
  localparam status_t ST_DIV0     = 4'd8;
  localparam status_t ST_BAD_ADDR = 4'd9;
  localparam status_t ST_BAD_DEV  = 4'd10;
  localparam status_t ST_IO       = 4'd11;

  localparam opcode_t OP_NOP    = 8'd0;
  localparam opcode_t OP_LIT    = 8'd1;
  localparam opcode_t OP_DUP    = 8'd2;
  localparam opcode_t OP_DROP   = 8'd3;
  localparam opcode_t OP_SWAP   = 8'd4;
  localparam opcode_t OP_PUSH   = 8'd5;
  localparam opcode_t OP_POP    = 8'd6;
  localparam opcode_t OP_JUMP   = 8'd7;
  localparam opcode_t OP_CALL   = 8'd8;
  localparam opcode_t OP_CCALL  = 8'd9;
  localparam opcode_t OP_RET    = 8'd10;
  localparam opcode_t OP_EQ     = 8'd11;
  localparam opcode_t OP_NE     = 8'd12;
  localparam opcode_t OP_LT     = 8'd13;
  localparam opcode_t OP_GT     = 8'd14;
  localparam opcode_t OP_FETCH  = 8'd15;
  localparam opcode_t OP_STORE  = 8'd16;
  localparam opcode_t OP_ADD    = 8'd17;
  localparam opcode_t OP_SUB    = 8'd18;
  localparam opcode_t OP_MUL    = 8'd19;
  localparam opcode_t OP_DIVMOD = 8'd20;
  localparam opcode_t OP_AND    = 8'd21;
  localparam opcode_t OP_OR     = 8'd22;
  localparam opcode_t OP_XOR    = 8'd23;
  localparam opcode_t OP_SHIFT  = 8'd24;
  localparam opcode_t OP_ZRET   = 8'd25;
  localparam opcode_t OP_HALT   = 8'd26;
  localparam opcode_t OP_ENUM   = 8'd27;
  localparam opcode_t OP_QUERY  = 8'd28;
  localparam opcode_t OP_INVOKE = 8'd29;
  localparam opcode_t OP_LAST   = OP_INVOKE;

  localparam rdir_t RS_NONE = 2'd0;
  localparam rdir_t RS_POP  = 2'd1;
  localparam rdir_t RS_PUSH = 2'd2;

  // Cells an opcode consumes from the data stack.
  function automatic logic [1:0] need_n(opcode_t op);
    logic [1:0] n;
    n = 2'd2;
    if (op == OP_NOP || op == OP_LIT || op == OP_POP || op == OP_RET || op == OP_HALT ||
        op > OP_LAST) begin
      n = 2'd0;
    end else if (op == OP_DUP || op == OP_DROP || op == OP_PUSH || op == OP_JUMP ||
                 op == OP_CALL || op == OP_FETCH || op == OP_ZRET || op == OP_ENUM ||
                 op == OP_QUERY || op == OP_INVOKE) begin
      n = 2'd1;
    end
    return n;
  endfunction

  // Room an opcode needs on the data stack.
  function automatic logic [1:0] need_m(opcode_t op);
    logic [1:0] m;
    m = 2'd0;
    if (op == OP_DUP || op == OP_SWAP || op == OP_DIVMOD || op == OP_ENUM) begin
      m = 2'd2;
    end else if (op == OP_LIT || op == OP_POP || (op >= OP_EQ && op <= OP_FETCH) ||
                 (op >= OP_ADD && op <= OP_MUL) || (op >= OP_AND && op <= OP_SHIFT) ||
                 op == OP_QUERY) begin
      m = 2'd1;
    end
    return m;
  endfunction

  // Direction in which an opcode moves the return stack.
  function automatic rdir_t need_r(opcode_t op);
    rdir_t r;
    r = RS_NONE;
    if (op == OP_PUSH || op == OP_CALL || op == OP_CCALL) begin
      r = RS_PUSH;
    end else if (op == OP_POP || op == OP_RET) begin
      r = RS_POP;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/pscc_div.sv
// Iterative divider of the packed stack core: one quotient bit per cycle.
// Depends on pscc_pkg for the cell type and width.
module pscc_div
  import pscc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  is_signed,
  input  cell_t dividend,
  input  cell_t divisor,
  output logic  done,
  output cell_t quotient,
  output cell_t remainder
);

  localparam int CW = $clog2(CELL_BITS);

  logic [CW-1:0]  count;
  logic           active;
  logic           neg_q;
  logic           neg_r;
  cell_t          quo;
  cell_t          rem;
  cell_t          den;
  logic [CELL_BITS:0] shifted;
  logic [CELL_BITS:0] trial;

  assign shifted = {rem, quo[CELL_BITS-1]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        count  <= '0;
        den    <= (is_signed && divisor[CELL_BITS-1]) ? cell_t'(-divisor) : divisor;
        quo    <= (is_signed && dividend[CELL_BITS-1]) ? cell_t'(-dividend) : dividend;
        rem    <= '0;
        neg_q  <= is_signed && (divisor[CELL_BITS-1] ^ dividend[CELL_BITS-1]);
        neg_r  <= is_signed && dividend[CELL_BITS-1];
      end else if (active) begin
        if (!trial[CELL_BITS]) begin
          rem <= trial[CELL_BITS-1:0];
          quo <= {quo[CELL_BITS-2:0], 1'b1};
        end else begin
          rem <= shifted[CELL_BITS-1:0];
          quo <= {quo[CELL_BITS-2:0], 1'b0};
        end
        count <= count + 1'b1;
        if (count == CW'(CELL_BITS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient  = neg_q ? cell_t'(-quo) : quo;
  assign remainder = neg_r ? cell_t'(-rem) : rem;

endmodule

FILE: hw/rtl/packed_stack_cpu_core.sv
// Top level of the packed stack core: sequencer, stacks, main memory and shared ALU.
// Depends on pscc_pkg and pscc_div.
//
//   channel   handshake                  payload
//   input     start, busy                mode, address, load_value
//   result    result_valid (strobe)      status, next_ip, top_value, device_id, io_kind, last
//   config    cfg_valid, cfg_ready       cfg_data (device count)
//
// Load, start and arm items pass S_IDLE, S_TOP and S_EMIT; an execute item runs S_DECODE,
// then per slot S_SLOT, S_EXEC (not for a nop) and S_NEXT, then S_END, S_TOP and S_EMIT;
// a literal or memory fetch adds S_MEMWR, a swap S_WR2, a divide S_DIV and S_WR2, and an
// io request emits via S_TOP and S_EMIT mid-bundle. A bad opcode word goes from S_DECODE
// to S_TOP; a fault or halt skips the rest of the bundle. The one data stack write port and
// the one main memory port call for the extra states. After reset the main memory is cleared
// one word a cycle with busy high. Results cannot be stalled; each is shown for one cycle.
module packed_stack_cpu_core
  import pscc_pkg::*;
#(
  parameter int MEM_WORDS    = 4096,
  parameter int DATA_DEPTH   = 32,
  parameter int RETURN_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [11:0]        address,
  input  logic signed [31:0] load_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data,
  output logic               result_valid,
  output logic [3:0]         status,
  output logic [12:0]        next_ip,
  output logic signed [31:0] top_value,
  output logic [3:0]         device_id,
  output logic               io_kind,
  output logic               last
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam int DW = $clog2(DATA_DEPTH);
  localparam int RW = $clog2(RETURN_DEPTH);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_SLOT   = 4'd3;
  localparam logic [3:0] S_EXEC   = 4'd4;
  localparam logic [3:0] S_MEMWR  = 4'd5;
  localparam logic [3:0] S_WR2    = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_NEXT   = 4'd8;
  localparam logic [3:0] S_END    = 4'd9;
  localparam logic [3:0] S_TOP    = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;

  logic [3:0]    state;
  logic [AW-1:0] clr_addr;
  logic [DW-1:0] dd;
  logic [RW-1:0] rd;
  cell_t         ip;
  logic          uflag;
  logic          running;
  logic          rs1_written;
  logic [4:0]    dev_count;
  cell_t         word;
  logic [1:0]    slot;
  status_t       stat;
  logic          emit_io;
  logic [3:0]    io_dev;
  logic          io_kind_r;
  logic [DW-1:0] wr_idx;
  cell_t         wr_data;
  logic [DW-1:0] mw_idx;

  cell_t main_mem [MEM_WORDS];
  cell_t ds_mem [DATA_DEPTH];
  cell_t rs_mem [RETURN_DEPTH];
  cell_t mem_q;
  cell_t ds_q0;
  cell_t ds_q1;
  cell_t rs_q;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;
  cell_t         mem_wd;
  logic          ds_we;
  logic [DW-1:0] ds_wa;
  cell_t         ds_wd;
  logic          rs_we;
  logic [RW-1:0] rs_wa;
  cell_t         rs_wd;
  logic [DW-1:0] dd_m1;

  opcode_t       cur_op;
  cell_t         tv;
  cell_t         sv;
  cell_t         rv;
  cell_t         lit_a;
  cell_t         ip_inc;
  status_t       guard_st;
  status_t       ex_fault;
  cell_t         alu_r;
  cell_t         shl_cnt;
  logic          fetch_special;
  cell_t         fetch_val;
  logic          bad_word;
  logic          addr_ok;
  logic [DW+1:0] room_lhs;
  logic [DW+1:0] room_rhs;
  logic          div_start;
  logic          div_done;
  cell_t         div_q;
  cell_t         div_r;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign dd_m1     = dd - 1'b1;
  assign cur_op    = word[{slot, 3'b000} +: 8];
  assign tv        = (dd != '0) ? ds_q0 : '0;
  assign sv        = (dd > DW'(1)) ? ds_q1 : '0;
  assign rv        = (rd == RW'(1) && !rs1_written) ? '0 : rs_q;
  assign lit_a     = ip + 1'b1;
  assign ip_inc    = ip + 1'b1;
  assign shl_cnt   = cell_t'(-tv);
  assign addr_ok   = 32'(address) < 32'(MEM_WORDS);

  always_comb begin
    bad_word = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (mem_q[8*i +: 8] > OP_LAST) begin
        bad_word = 1'b1;
      end
    end
  end

  // Stack guard, checked before any opcode touches state.
  always_comb begin
    room_lhs = (DW+2)'(dd) + (DW+2)'(need_m(cur_op));
    room_rhs = (DW+2)'(need_n(cur_op)) + (DW+2)'(DATA_DEPTH - 1);
    guard_st = ST_OK;
    if (dd < DW'(need_n(cur_op))) begin
      guard_st = ST_D_UNDER;
    end else if (room_lhs > room_rhs) begin
      guard_st = ST_D_OVER;
    end else if (need_r(cur_op) == RS_POP && rd == '0) begin
      guard_st = ST_R_UNDER;
    end else if (need_r(cur_op) == RS_PUSH && (RW+1)'(rd) + 1'b1 > (RW+1)'(RETURN_DEPTH - 1))
    begin
      guard_st = ST_R_OVER;
    end
  end

  always_comb begin
    fetch_special = 1'b1;
    unique case (tv)
      32'hFFFF_FFFF: fetch_val = cell_t'(dd_m1);
      32'hFFFF_FFFE: fetch_val = cell_t'(rd);
      32'hFFFF_FFFD: fetch_val = cell_t'(MEM_WORDS);
      32'hFFFF_FFFC: fetch_val = 32'h8000_0000;
      32'hFFFF_FFFB: fetch_val = 32'h7FFF_FFFF;
      default: begin
        fetch_special = 1'b0;
        fetch_val     = '0;
      end
    endcase
  end

  always_comb begin
    ex_fault = ST_OK;
    if (guard_st != ST_OK) begin
      ex_fault = guard_st;
    end else begin
      unique case (cur_op)
        OP_LIT:   if (lit_a >= cell_t'(MEM_WORDS)) ex_fault = ST_BAD_ADDR;
        OP_FETCH: if (!fetch_special && tv >= cell_t'(MEM_WORDS)) ex_fault = ST_BAD_ADDR;
        OP_STORE: if (tv >= cell_t'(MEM_WORDS)) ex_fault = ST_BAD_ADDR;
        OP_DIVMOD: if (tv == '0) ex_fault = ST_DIV0;
        OP_ZRET:  if (tv == '0 && rd == '0) ex_fault = ST_R_UNDER;
        OP_HALT:  ex_fault = ST_HALTED;
        OP_QUERY, OP_INVOKE: begin
          if (tv >= cell_t'(dev_count) || tv >= cell_t'(MAX_DEV)) ex_fault = ST_BAD_DEV;
        end
        default: ex_fault = ST_OK;
      endcase
    end
  end

  // Shared ALU for compares, arithmetic, logic and shifts.
  always_comb begin
    unique case (cur_op)
      OP_EQ:  alu_r = (sv == tv) ? '1 : '0;
      OP_NE:  alu_r = (sv != tv) ? '1 : '0;
      OP_LT:  alu_r = (uflag ? (sv < tv) : ($signed(sv) < $signed(tv))) ? '1 : '0;
      OP_GT:  alu_r = (uflag ? (tv < sv) : ($signed(tv) < $signed(sv))) ? '1 : '0;
      OP_ADD: alu_r = sv + tv;
      OP_SUB: alu_r = sv - tv;
      OP_MUL: alu_r = sv * tv;
      OP_AND: alu_r = sv & tv;
      OP_OR:  alu_r = sv | tv;
      OP_XOR: alu_r = sv ^ tv;
      OP_SHIFT: begin
        if (tv[CELL_BITS-1]) begin
          alu_r = (shl_cnt >= cell_t'(CELL_BITS)) ? '0 : sv << shl_cnt[4:0];
        end else if (uflag) begin
          alu_r = (tv >= cell_t'(CELL_BITS)) ? '0 : sv >> tv[4:0];
        end else if (tv >= cell_t'(CELL_BITS)) begin
          alu_r = {CELL_BITS{sv[CELL_BITS-1]}};
        end else begin
          alu_r = cell_t'($signed(sv) >>> tv[4:0]);
        end
      end
      default: alu_r = '0;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = '0;
    mem_ra = ip[AW-1:0];
    ds_we  = 1'b0;
    ds_wa  = dd;
    ds_wd  = alu_r;
    rs_we  = 1'b0;
    rs_wa  = rd + 1'b1;
    rs_wd  = ip;
    unique case (state)
      S_CLEAR: mem_we = 1'b1;
      S_IDLE: begin
        if (start && mode == MODE_LOAD && addr_ok) begin
          mem_we = 1'b1;
          mem_wa = address[AW-1:0];
          mem_wd = cell_t'(load_value);
        end
      end
      S_EXEC: begin
        if (ex_fault == ST_OK) begin
          unique case (cur_op)
            OP_LIT: mem_ra = lit_a[AW-1:0];
            OP_FETCH: begin
              mem_ra = tv[AW-1:0];
              ds_we  = fetch_special;
              ds_wd  = fetch_val;
            end
            OP_STORE: begin
              mem_we = 1'b1;
              mem_wa = tv[AW-1:0];
              mem_wd = sv;
            end
            OP_DUP: begin
              ds_we = 1'b1;
              ds_wa = dd + 1'b1;
              ds_wd = sv;
            end
            OP_SWAP: begin
              ds_we = 1'b1;
              ds_wd = sv;
            end
            OP_POP: begin
              ds_we = 1'b1;
              ds_wa = dd + 1'b1;
              ds_wd = rv;
            end
            OP_ENUM: begin
              ds_we = 1'b1;
              ds_wa = dd + 1'b1;
              ds_wd = cell_t'(dev_count);
            end
            OP_EQ, OP_NE, OP_LT, OP_GT, OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR,
            OP_SHIFT: begin
              ds_we = 1'b1;
              ds_wa = dd_m1;
            end
            OP_PUSH: begin
              rs_we = 1'b1;
              rs_wd = tv;
            end
            OP_CALL:  rs_we = 1'b1;
            OP_CCALL: rs_we = (sv != '0);
            default: ds_we = 1'b0;
          endcase
        end
      end
      S_MEMWR: begin
        ds_we = 1'b1;
        ds_wa = mw_idx;
        ds_wd = mem_q;
      end
      S_WR2: begin
        ds_we = 1'b1;
        ds_wa = wr_idx;
        ds_wd = wr_data;
      end
      S_DIV: begin
        ds_we = div_done;
        ds_wd = div_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      main_mem[mem_wa] <= mem_wd;
    end
    mem_q <= main_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (ds_we) begin
      ds_mem[ds_wa] <= ds_wd;
    end
    ds_q0 <= ds_mem[dd];
    ds_q1 <= ds_mem[dd_m1];
  end

  always_ff @(posedge clk) begin
    if (rs_we) begin
      rs_mem[rs_wa] <= rs_wd;
    end
    rs_q <= rs_mem[rd];
  end

  pscc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .is_signed (!uflag),
    .dividend  (sv),
    .divisor   (tv),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      dd          <= '0;
      rd          <= '0;
      ip          <= '0;
      uflag       <= 1'b0;
      running     <= 1'b0;
      rs1_written <= 1'b0;
      dev_count   <= '0;
      slot        <= '0;
      stat        <= ST_OK;
      emit_io     <= 1'b0;
      div_start   <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        dev_count <= cfg_data;
      end
      // Only the first return stack entry can be read before it is written.
      if (rs_we && rs_wa == RW'(1)) begin
        rs1_written <= 1'b1;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MEM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            emit_io <= 1'b0;
            stat    <= ST_OK;
            state   <= S_TOP;
            unique case (mode)
              MODE_LOAD: stat <= ST_OK;
              MODE_START: begin
                if (rd == '0) begin
                  rd <= RW'(1);
                end
                if (addr_ok) begin
                  ip      <= cell_t'(address);
                  running <= 1'b1;
                end else begin
                  running <= 1'b0;
                  rd      <= '0;
                  ip      <= cell_t'(MEM_WORDS);
                  stat    <= ST_FINISHED;
                end
              end
              MODE_EXEC: begin
                if (!running) begin
                  stat <= ST_FINISHED;
                end else begin
                  state <= S_DECODE;
                end
              end
              MODE_ARM: uflag <= 1'b1;
              default: stat <= ST_OK;
            endcase
          end
        end
        S_DECODE: begin
          word <= mem_q;
          slot <= '0;
          if (bad_word) begin
            running <= 1'b0;
            rd      <= '0;
            ip      <= cell_t'(MEM_WORDS);
            stat    <= ST_BAD_OP;
            state   <= S_TOP;
          end else begin
            state <= S_SLOT;
          end
        end
        S_SLOT: state <= (cur_op == OP_NOP) ? S_NEXT : S_EXEC;
        S_EXEC: begin
          state <= S_NEXT;
          if (ex_fault != ST_OK) begin
            running <= 1'b0;
            rd      <= '0;
            ip      <= cell_t'(MEM_WORDS);
            stat    <= ex_fault;
            state   <= S_TOP;
          end else begin
            unique case (cur_op)
              OP_LIT: begin
                ip     <= lit_a;
                dd     <= dd + 1'b1;
                mw_idx <= dd + 1'b1;
                state  <= S_MEMWR;
              end
              OP_DUP, OP_POP, OP_ENUM: begin
                dd <= dd + 1'b1;
                if (cur_op == OP_POP) begin
                  rd <= rd - 1'b1;
                end
              end
              OP_DROP, OP_EQ, OP_NE, OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR,
              OP_LT, OP_GT: begin
                dd <= dd_m1;
                if (cur_op != OP_DROP && cur_op != OP_AND && cur_op != OP_OR &&
                    cur_op != OP_XOR) begin
                  uflag <= 1'b0;
                end
              end
              OP_SHIFT: begin
                dd <= dd_m1;
                if (!tv[CELL_BITS-1]) begin
                  uflag <= 1'b0;
                end
              end
              OP_SWAP: begin
                wr_idx  <= dd_m1;
                wr_data <= tv;
                state   <= S_WR2;
              end
              OP_PUSH: begin
                rd <= rd + 1'b1;
                dd <= dd_m1;
              end
              OP_JUMP: begin
                ip <= tv - 1'b1;
                dd <= dd_m1;
              end
              OP_CALL: begin
                rd <= rd + 1'b1;
                ip <= tv - 1'b1;
                dd <= dd_m1;
              end
              OP_CCALL: begin
                dd <= dd - 2'd2;
                if (sv != '0) begin
                  rd <= rd + 1'b1;
                  ip <= tv - 1'b1;
                end
              end
              OP_RET: begin
                ip <= rv;
                rd <= rd - 1'b1;
              end
              OP_FETCH: begin
                if (!fetch_special) begin
                  mw_idx <= dd;
                  state  <= S_MEMWR;
                end
              end
              OP_STORE: dd <= dd - 2'd2;
              OP_DIVMOD: begin
                div_start <= 1'b1;
                state     <= S_DIV;
              end
              OP_ZRET: begin
                if (tv == '0) begin
                  dd <= dd_m1;
                  ip <= rv;
                  rd <= rd - 1'b1;
                end
              end
              OP_QUERY, OP_INVOKE: begin
                dd        <= dd_m1;
                emit_io   <= 1'b1;
                io_dev    <= tv[3:0];
                io_kind_r <= (cur_op == OP_INVOKE);
                stat      <= ST_IO;
                state     <= S_TOP;
              end
              default: state <= S_NEXT;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            uflag   <= 1'b0;
            wr_idx  <= dd_m1;
            wr_data <= div_r;
            state   <= S_WR2;
          end
        end
        S_MEMWR, S_WR2: state <= S_NEXT;
        S_NEXT: begin
          if (slot == 2'd3) begin
            state <= S_END;
          end else begin
            slot  <= slot + 1'b1;
            state <= S_SLOT;
          end
        end
        S_END: begin
          state <= S_TOP;
          stat  <= ST_OK;
          ip    <= ip_inc;
          if (rd == '0 || ip_inc[CELL_BITS-1] || ip_inc >= cell_t'(MEM_WORDS)) begin
            running <= 1'b0;
            rd      <= '0;
            ip      <= cell_t'(MEM_WORDS);
            stat    <= (rd != '0 && ip_inc[CELL_BITS-1]) ? ST_BAD_ADDR : ST_FINISHED;
          end
        end
        S_TOP: state <= S_EMIT;
        S_EMIT: begin
          emit_io <= 1'b0;
          state   <= emit_io ? S_NEXT : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result_valid = (state == S_EMIT);
  assign status       = stat;
  assign next_ip      = (emit_io || running) ? ip[12:0] : 13'(MEM_WORDS);
  assign top_value    = (dd != '0) ? ds_q0 : '0;
  assign device_id    = emit_io ? io_dev : '0;
  assign io_kind      = emit_io && io_kind_r;
  assign last         = !emit_io;

endmodule

FILE: hw/rtl/pscc_check.sv
// Port-level checker of the packed stack core, bound to the top level below.
// Depends on pscc_pkg for the status codes.
module pscc_check
  import pscc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_valid,
  input logic [3:0]  status,
  input logic [3:0]  device_id,
  input logic        io_kind,
  input logic        last
);

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result shown while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transfer did not raise busy");

  a_io_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> status == ST_IO) else $error("non-final result is not io");

  a_final_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> device_id == 4'd0 && !io_kind)
    else $error("final result carries device fields");

  a_final_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid) else $error("result right after final result");

endmodule

bind packed_stack_cpu_core pscc_check u_pscc_check (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .status       (status),
  .device_id    (device_id),
  .io_kind      (io_kind),
  .last         (last)
);

FILE: tb/sv/packed_stack_cpu_core_checker.sv
// Result checker for the packed stack core: predicts every result from the input and
// configuration transfers it sees and compares the result strobes against them.
// Depends on pscc_pkg for the status, mode and opcode codes.
module packed_stack_cpu_core_checker
  import pscc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         mode,
  input  logic [11:0]        address,
  input  logic signed [31:0] load_value,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [4:0]         cfg_data,
  input  logic               result_valid,
  input  logic [3:0]         status,
  input  logic [12:0]        next_ip,
  input  logic signed [31:0] top_value,
  input  logic [3:0]         device_id,
  input  logic               io_kind,
  input  logic               last,
  output int                 errors,
  output int                 pending
);

  localparam int WORDS = 4096;
  localparam int DSLOTS = 32;
  localparam int RSLOTS = 128;

  localparam int TAKES[30] = '{0,0,1,1,2,1,0,1,1,2,0,2,2,2,2,1,2,2,2,2,2,2,2,2,2,1,0,1,1,1};
  localparam int ROOM[30]  = '{0,1,2,0,2,0,1,0,0,0,0,1,1,1,1,1,0,1,1,1,2,1,1,1,1,0,0,2,1,0};
  localparam int RMOVE[30] = '{0,0,0,0,0,1,-1,0,1,1,-1,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0};

  typedef struct packed {
    status_t     st;
    logic [12:0] ip;
    cell_t       top;
    logic [3:0]  dev;
    logic        kind;
    logic        fin;
  } core_result_t;

  core_result_t result_q[$];
  cell_t        mem[WORDS];
  cell_t        dstk[DSLOTS];
  cell_t        rstk[RSLOTS];
  int           dd;
  int           rd;
  cell_t        ip;
  bit           uflag;
  bit           run;
  logic [4:0]   ndev;

  function automatic void post(status_t st, logic [12:0] ipv, logic [3:0] dev, logic kind,
                               logic fin);
    core_result_t r;
    r.st   = st;
    r.ip   = ipv;
    r.top  = dd != 0 ? dstk[dd] : '0;
    r.dev  = dev;
    r.kind = kind;
    r.fin  = fin;
    result_q.push_back(r);
  endfunction

  function automatic void halt_core();
    run = 0;
    rd  = 0;
    ip  = WORDS;
  endfunction

  function automatic void enter(cell_t target);
    rd++;
    rstk[rd] = ip;
    ip = target - 1;
  endfunction

  function automatic status_t guard(opcode_t op);
    if (dd < TAKES[op]) return ST_D_UNDER;
    if (dd + ROOM[op] > TAKES[op] + DSLOTS - 1) return ST_D_OVER;
    if (RMOVE[op] < 0 && rd == 0) return ST_R_UNDER;
    if (RMOVE[op] > 0 && rd + 1 > RSLOTS - 1) return ST_R_OVER;
    return ST_OK;
  endfunction

  function automatic status_t run_op(opcode_t op);
    status_t g;
    cell_t t, s, a, b, q, rem, r;
    bit u;
    g = guard(op);
    if (g != ST_OK) return g;
    u = uflag;
    t = dd != 0 ? dstk[dd] : '0;
    s = dd > 1 ? dstk[dd-1] : '0;
    r = '0;
    case (op)
      OP_LIT: begin
        a = ip + 1;
        if (a >= WORDS) return ST_BAD_ADDR;
        ip = a;
        dd++;
        dstk[dd] = mem[a[11:0]];
      end
      OP_DUP: begin
        dd++;
        dstk[dd] = s;
      end
      OP_DROP: dd--;
      OP_SWAP: begin
        dstk[dd] = s;
        dstk[dd-1] = t;
      end
      OP_PUSH: begin
        rd++;
        rstk[rd] = t;
        dd--;
      end
      OP_POP: begin
        dd++;
        dstk[dd] = rstk[rd];
        rd--;
      end
      OP_JUMP: begin
        ip = t - 1;
        dd--;
      end
      OP_CALL: begin
        enter(t);
        dd--;
      end
      OP_CCALL: begin
        dd -= 2;
        if (s != 0) enter(t);
      end
      OP_RET: begin
        ip = rstk[rd];
        rd--;
      end
      OP_EQ, OP_NE, OP_LT, OP_GT, OP_ADD, OP_SUB, OP_MUL: begin
        case (op)
          OP_EQ:   r = s == t ? '1 : '0;
          OP_NE:   r = s != t ? '1 : '0;
          OP_LT:   r = (u ? s < t : $signed(s) < $signed(t)) ? '1 : '0;
          OP_GT:   r = (u ? t < s : $signed(t) < $signed(s)) ? '1 : '0;
          OP_ADD:  r = s + t;
          OP_SUB:  r = s - t;
          default: r = s * t;
        endcase
        uflag = 0;
        dstk[dd-1] = r;
        dd--;
      end
      OP_FETCH: begin
        if (t == 32'hFFFF_FFFF) r = dd - 1;
        else if (t == 32'hFFFF_FFFE) r = rd;
        else if (t == 32'hFFFF_FFFD) r = WORDS;
        else if (t == 32'hFFFF_FFFC) r = 32'h8000_0000;
        else if (t == 32'hFFFF_FFFB) r = 32'h7FFF_FFFF;
        else if (t < WORDS) r = mem[t[11:0]];
        else return ST_BAD_ADDR;
        dstk[dd] = r;
      end
      OP_STORE: begin
        if (t >= WORDS) return ST_BAD_ADDR;
        mem[t[11:0]] = s;
        dd -= 2;
      end
      OP_DIVMOD: begin
        if (t == 0) return ST_DIV0;
        if (u) begin
          q = s / t;
          rem = s % t;
        end else begin
          a = t[31] ? -t : t;
          b = s[31] ? -s : s;
          q = b / a;
          rem = b % a;
          if (t[31] != s[31]) q = -q;
          if (s[31]) rem = -rem;
        end
        uflag = 0;
        dstk[dd] = q;
        dstk[dd-1] = rem;
      end
      OP_AND: begin
        dstk[dd-1] = s & t;
        dd--;
      end
      OP_OR: begin
        dstk[dd-1] = s | t;
        dd--;
      end
      OP_XOR: begin
        dstk[dd-1] = s ^ t;
        dd--;
      end
      OP_SHIFT: begin
        if (t[31]) begin
          a = -t;
          r = a >= CELL_BITS ? '0 : s << a[4:0];
        end else if (u) begin
          r = t >= CELL_BITS ? '0 : s >> t[4:0];
          uflag = 0;
        end else if (t >= CELL_BITS) begin
          r = s[31] ? '1 : '0;
        end else begin
          r = cell_t'($signed(s) >>> t[4:0]);
        end
        dstk[dd-1] = r;
        dd--;
      end
      OP_ZRET: begin
        if (t == 0) begin
          if (rd == 0) return ST_R_UNDER;
          dd--;
          ip = rstk[rd];
          rd--;
        end
      end
      OP_HALT: return ST_HALTED;
      OP_ENUM: begin
        dd++;
        dstk[dd] = ndev;
      end
      OP_QUERY, OP_INVOKE: begin
        if (t >= ndev || t >= MAX_DEV) return ST_BAD_DEV;
        dd--;
        post(ST_IO, ip[12:0], t[3:0], op == OP_INVOKE, 1'b0);
      end
      default: ;
    endcase
    return ST_OK;
  endfunction

  function automatic status_t run_bundle();
    cell_t   w;
    opcode_t op;
    status_t st;
    w = mem[ip[11:0]];
    for (int i = 0; i < 4; i++) begin
      if (w[8*i +: 8] > OP_LAST) begin
        halt_core();
        return ST_BAD_OP;
      end
    end
    for (int i = 0; i < 4; i++) begin
      op = w[8*i +: 8];
      if (op != OP_NOP) begin
        st = run_op(op);
        if (st != ST_OK) begin
          halt_core();
          return st;
        end
      end
    end
    ip = ip + 1;
    if (rd == 0) begin
      halt_core();
      return ST_FINISHED;
    end
    if (ip[31]) begin
      halt_core();
      return ST_BAD_ADDR;
    end
    if (ip >= WORDS) begin
      halt_core();
      return ST_FINISHED;
    end
    return ST_OK;
  endfunction

  function automatic void predict_item(mode_t m, logic [11:0] a, cell_t v);
    status_t st;
    st = ST_OK;
    case (m)
      MODE_LOAD: mem[a] = v;
      MODE_START: begin
        if (rd == 0) rd = 1;
        ip  = a;
        run = 1;
      end
      MODE_EXEC: st = run ? run_bundle() : ST_FINISHED;
      default: uflag = 1;
    endcase
    post(st, run ? ip[12:0] : 13'(WORDS), 4'd0, 1'b0, 1'b1);
  endfunction

  always @(posedge clk) begin
    core_result_t e;
    if (rst) begin
      result_q.delete();
      foreach (mem[i]) mem[i] = '0;
      foreach (dstk[i]) dstk[i] = '0;
      foreach (rstk[i]) rstk[i] = '0;
      dd = 0;
      rd = 0;
      ip = '0;
      uflag = 0;
      run = 0;
      ndev = '0;
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) ndev = cfg_data;
      if (result_valid) begin
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: status %0d ip %0d", status, next_ip);
        end else begin
          e = result_q.pop_front();
          if (status !== e.st || next_ip !== e.ip || top_value !== e.top ||
              device_id !== e.dev || io_kind !== e.kind || last !== e.fin) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected st %0d ip %0d top %h dev %0d kind %0d last %0d",
                       e.st, e.ip, e.top, e.dev, e.kind, e.fin);
              $display("          actual   st %0d ip %0d top %h dev %0d kind %0d last %0d",
                       status, next_ip, top_value, device_id, io_kind, last);
            end
          end
        end
      end
      if (start && !busy) predict_item(mode, address, load_value);
    end
    pending <= result_q.size();
  end

endmodule

FILE: tb/sv/packed_stack_cpu_core_tb.sv
// Top of the packed stack core testbench: clock, reset, directed and random programs,
// device count changes and the verdict. Depends on pscc_pkg, the core and the result checker.
module packed_stack_cpu_core_tb
  import pscc_pkg::*;
;

  localparam int ITEMS = 350;
  localparam int STALL_LIMIT = 20000;

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy;
  logic [1:0]         mode = '0;
  logic [11:0]        address = '0;
  logic signed [31:0] load_value = '0;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [4:0]         cfg_data = '0;
  logic               result_valid;
  logic [3:0]         status;
  logic [12:0]        next_ip;
  logic signed [31:0] top_value;
  logic [3:0]         device_id;
  logic               io_kind;
  logic               last;
  int                 errors;
  int                 pending;
  int                 sent = 0;
  int                 stall_cycles = 0;
  bit                 gaps_on = 1;

  always #4 clk = ~clk;

  packed_stack_cpu_core dut (.*);

  packed_stack_cpu_core_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send(mode_t m, logic [11:0] a, cell_t v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1;
    mode <= m;
    address <= a;
    load_value <= v;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_devices(logic [4:0] n);
    cfg_valid <= 1;
    cfg_data <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic cell_t pick_cell();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 40);
      1: return -cell_t'($urandom_range(1, 5));
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 4095);
      5: return cell_t'($urandom_range(0, 80)) - 40;
      default: return $urandom;
    endcase
  endfunction

  function automatic cell_t code_word();
    cell_t w;
    int p;
    for (int i = 0; i < 4; i++) begin
      p = $urandom_range(0, 99);
      if (p < 3) w[8*i +: 8] = 8'($urandom_range(OP_LAST + 1, 255));
      else if (p < 28) w[8*i +: 8] = OP_LIT;
      else w[8*i +: 8] = 8'($urandom_range(0, OP_LAST));
    end
    return w;
  endfunction

  task automatic random_program();
    logic [11:0] base;
    int n;
    base = $urandom_range(0, 9) == 0 ? 12'($urandom_range(4080, 4095)) : 12'($urandom);
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      send(MODE_LOAD, base + 12'(i), $urandom_range(0, 9) < 6 ? code_word() : pick_cell());
    if ($urandom_range(0, 9) == 0) send(mode_t'($urandom_range(0, 3)), 12'($urandom), $urandom);
    send(MODE_START, base, $urandom);
    for (int i = 0; i < n + 2; i++) begin
      if ($urandom_range(0, 9) == 0) send(MODE_ARM, 12'($urandom), $urandom);
      send(MODE_EXEC, 12'($urandom), $urandom);
    end
  endtask

  initial begin
    logic [4:0] counts[4];
    int phase;
    counts = '{5'd0, 5'd16, 5'd31, 5'($urandom_range(1, 15))};
    repeat (2) @(posedge clk);
    rst <= 0;
    set_devices(5'd4);

    send(MODE_LOAD, 12'd4095, 32'h7FFF_FFFF);
    send(MODE_LOAD, 12'd0, 32'h8000_0000);
    send(MODE_EXEC, 12'd0, '0);
    send(MODE_LOAD, 12'd10, {OP_QUERY, OP_DIVMOD, OP_LIT, OP_LIT});
    send(MODE_LOAD, 12'd11, 32'h8000_0000);
    send(MODE_LOAD, 12'd12, 32'hFFFF_FFFF);
    send(MODE_LOAD, 12'd13, {OP_INVOKE, OP_LIT, OP_ENUM, OP_DUP});
    send(MODE_LOAD, 12'd14, 32'd2);
    send(MODE_LOAD, 12'd15, {OP_DIVMOD, OP_LIT, OP_SHIFT, OP_LIT});
    send(MODE_LOAD, 12'd16, 32'hFFFF_FFFF);
    send(MODE_LOAD, 12'd17, 32'd0);
    send(MODE_START, 12'd10, '0);
    send(MODE_EXEC, '0, '0);
    send(MODE_START, 12'd13, '0);
    send(MODE_EXEC, '0, '0);
    send(MODE_EXEC, '0, '0);
    send(MODE_ARM, 12'hFFF, 32'hFFFF_FFFF);
    send(MODE_LOAD, 12'd20, {OP_HALT, OP_ZRET, OP_CCALL, OP_STORE});
    send(MODE_START, 12'd20, '0);
    send(MODE_EXEC, '0, '0);
    send(MODE_START, 12'd4095, '0);
    send(MODE_EXEC, '0, '0);
    send(MODE_ARM, '0, '0);

    phase = 0;
    while (sent < ITEMS) begin
      if (sent >= 60 + 70 * phase && phase < 4) begin
        drain();
        set_devices(counts[phase]);
        phase++;
      end
      gaps_on = sent < 300 && $urandom_range(0, 3) != 0;
      random_program();
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
